// File: sv/sqb_pkg.sv
// Shared types and constants for the sorted quote book.
// Used by the controller, the datapath and the top level; no dependencies.
package sqb_pkg;

    localparam logic [1:0] OP_NEW    = 2'd0;
    localparam logic [1:0] OP_UPDATE = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;
    localparam logic [1:0] OP_QUERY  = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_MISSING   = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_NO_LEVEL  = 3'd4;

    localparam int ENTRY_W = 63 + 64 + 48;

    typedef enum logic [3:0] {
        S_IDLE, S_START, S_RM_RD, S_RM_CHK, S_SH_RD, S_SH_WR,
        S_INS_START, S_INS_RD, S_INS_CHK, S_IS_RD, S_IS_WR,
        S_Q_RD, S_Q_CHK, S_DONE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture input item
        logic rm_init;   // start removal scan
        logic ins_init;  // start insertion scan
        logic q_init;    // start level scan
        logic step;      // advance scan pointer
        logic rm_hit;    // entry removed: move to shift phase
        logic sh_wr;     // write shifted entry (removal)
        logic ins_hit;   // insert position found
        logic is_wr;     // write during insertion shift
        logic q_acc;     // accumulate level sums
        logic set_st;    // latch status code
        logic [2:0] st;
        logic fill_dec;
        logic fill_inc;
        logic out_load;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] op;
        logic       fill_zero;
        logic       full;
        logic       rkey_zero;
        logic       ptr_end;   // scan pointer reached fill
        logic       ptr_last;  // scan pointer at the last held entry
        logic       key_match;
        logic       here;
        logic       is_end;    // insertion shift reached position
        logic       q_done;    // wanted level closed by a new price
        logic       out_busy;
    } stat_t;

endpackage

// File: sv/sqb_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module sqb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: sv/sqb_ctrl.sv
// Controller state machine for the sorted quote book.
// Depends on sqb_pkg.
module sqb_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  sqb_pkg::stat_t  st,
    output sqb_pkg::cmd_t   cmd
);
    sqb_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sqb_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sqb_pkg::S_IDLE: if (s_valid) state_next = sqb_pkg::S_START;
            sqb_pkg::S_START: begin
                if (st.op == sqb_pkg::OP_QUERY) begin
                    state_next = sqb_pkg::S_Q_RD;
                end else if (st.op == sqb_pkg::OP_NEW) begin
                    state_next = sqb_pkg::S_INS_START;
                end else if (st.rkey_zero || st.fill_zero) begin
                    state_next = (st.op == sqb_pkg::OP_UPDATE) ? sqb_pkg::S_INS_START
                                                               : sqb_pkg::S_DONE;
                end else begin
                    state_next = sqb_pkg::S_RM_RD;
                end
            end
            sqb_pkg::S_RM_RD: state_next = sqb_pkg::S_RM_CHK;
            sqb_pkg::S_RM_CHK: begin
                if (st.key_match) begin
                    state_next = sqb_pkg::S_SH_RD;
                end else if (st.ptr_last) begin
                    state_next = (st.op == sqb_pkg::OP_UPDATE) ? sqb_pkg::S_INS_START
                                                               : sqb_pkg::S_DONE;
                end else begin
                    state_next = sqb_pkg::S_RM_RD;
                end
            end
            sqb_pkg::S_SH_RD: begin
                if (st.ptr_end) begin
                    state_next = (st.op == sqb_pkg::OP_UPDATE) ? sqb_pkg::S_INS_START
                                                               : sqb_pkg::S_DONE;
                end else begin
                    state_next = sqb_pkg::S_SH_WR;
                end
            end
            sqb_pkg::S_SH_WR: state_next = sqb_pkg::S_SH_RD;
            sqb_pkg::S_INS_START: begin
                if (st.full) begin
                    state_next = sqb_pkg::S_DONE;
                end else begin
                    state_next = sqb_pkg::S_INS_RD;
                end
            end
            sqb_pkg::S_INS_RD: begin
                if (st.ptr_end) begin
                    state_next = sqb_pkg::S_IS_RD;
                end else begin
                    state_next = sqb_pkg::S_INS_CHK;
                end
            end
            sqb_pkg::S_INS_CHK: begin
                if (st.here) begin
                    state_next = sqb_pkg::S_IS_RD;
                end else begin
                    state_next = sqb_pkg::S_INS_RD;
                end
            end
            sqb_pkg::S_IS_RD: begin
                if (st.is_end) begin
                    state_next = sqb_pkg::S_DONE;
                end else begin
                    state_next = sqb_pkg::S_IS_WR;
                end
            end
            sqb_pkg::S_IS_WR: state_next = sqb_pkg::S_IS_RD;
            sqb_pkg::S_Q_RD: begin
                if (st.ptr_end) begin
                    state_next = sqb_pkg::S_DONE;
                end else begin
                    state_next = sqb_pkg::S_Q_CHK;
                end
            end
            sqb_pkg::S_Q_CHK: begin
                if (st.q_done) begin
                    state_next = sqb_pkg::S_DONE;
                end else begin
                    state_next = sqb_pkg::S_Q_RD;
                end
            end
            sqb_pkg::S_DONE: if (!st.out_busy) state_next = sqb_pkg::S_IDLE;
            default: state_next = sqb_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            sqb_pkg::S_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            sqb_pkg::S_START: begin
                cmd.rm_init = 1'b1;
                cmd.q_init  = 1'b1;
                if ((st.op == sqb_pkg::OP_UPDATE || st.op == sqb_pkg::OP_DELETE)
                        && (st.rkey_zero || st.fill_zero)) begin
                    cmd.set_st = 1'b1;
                    cmd.st     = sqb_pkg::ST_MISSING;
                end
            end
            sqb_pkg::S_RM_RD: ;
            sqb_pkg::S_RM_CHK: begin
                if (st.key_match) begin
                    cmd.rm_hit   = 1'b1;
                    cmd.fill_dec = 1'b1;
                end else begin
                    cmd.step = 1'b1;
                    if (st.ptr_last) begin
                        cmd.set_st = 1'b1;
                        cmd.st     = sqb_pkg::ST_NOT_FOUND;
                    end
                end
            end
            sqb_pkg::S_SH_RD: ;
            sqb_pkg::S_SH_WR: begin
                cmd.sh_wr = 1'b1;
                cmd.step  = 1'b1;
            end
            sqb_pkg::S_INS_START: begin
                cmd.ins_init = 1'b1;
                if (st.full) begin
                    cmd.set_st = 1'b1;
                    cmd.st     = sqb_pkg::ST_FULL;
                end
            end
            sqb_pkg::S_INS_RD: begin
                if (st.ptr_end) begin
                    cmd.ins_hit = 1'b1;
                end
            end
            sqb_pkg::S_INS_CHK: begin
                if (st.here) begin
                    cmd.ins_hit = 1'b1;
                end else begin
                    cmd.step = 1'b1;
                end
            end
            sqb_pkg::S_IS_RD: begin
                if (st.is_end) begin
                    cmd.is_wr    = 1'b1;
                    cmd.fill_inc = 1'b1;
                end
            end
            sqb_pkg::S_IS_WR: cmd.is_wr = 1'b1;
            sqb_pkg::S_Q_RD: ;
            sqb_pkg::S_Q_CHK: begin
                // a new price after the wanted level ends the scan; keep its sums
                if (!st.q_done) begin
                    cmd.q_acc = 1'b1;
                    cmd.step  = 1'b1;
                end
            end
            sqb_pkg::S_DONE: cmd.out_load = !st.out_busy;
            default: ;
        endcase
    end

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == sqb_pkg::S_IDLE)
        else $error("ready outside idle");
    a_accept_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> state_reg == sqb_pkg::S_START)
        else $error("accepted item not started");
    a_one_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.fill_inc && cmd.fill_dec))
        else $error("fill moved both ways");
endmodule

// File: sv/sqb_dp.sv
// Datapath: side memories, scan pointer, fill counts, level sums, result register.
// Depends on sqb_pkg and sqb_ram.
module sqb_dp #(
    parameter int DEPTH       = 64,
    parameter int INSTRUMENTS = 4
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  sqb_pkg::cmd_t          cmd,
    output sqb_pkg::stat_t         st,
    input  logic [1:0]             s_op,
    input  logic [1:0]             s_instrument,
    input  logic                   s_side,
    input  logic [62:0]            s_quote_key,
    input  logic [62:0]            s_ref_key,
    input  logic signed [63:0]     s_price,
    input  logic [47:0]            s_volume,
    input  logic [5:0]             s_level_index,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [2:0]             m_status,
    output logic [6:0]             m_side_count,
    output logic signed [63:0]     m_level_price,
    output logic [53:0]            m_level_volume,
    output logic [6:0]             m_level_quotes
);
    localparam int SIDES = INSTRUMENTS * 2;
    localparam int SW    = (SIDES > 1) ? $clog2(SIDES) : 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int MA    = SW + AW;
    localparam int EW    = sqb_pkg::ENTRY_W;

    logic [1:0]         op_reg;
    logic [SW-1:0]      sd_reg;
    logic               bid_reg;
    logic [62:0]        qkey_reg, rkey_reg;
    logic signed [63:0] price_reg;
    logic [47:0]        vol_reg;
    logic [5:0]         want_reg;
    logic [CW-1:0]      fill_reg [SIDES];
    logic [CW-1:0]      ptr_reg, pos_reg;
    logic [2:0]         status_reg;
    logic               rm_ph_reg;    // removal shift copies ptr+1 -> ptr
    logic               ins_ph_reg;   // insertion shift copies ptr-1 -> ptr
    logic [53:0]        sum_reg;
    logic [CW-1:0]      cnt_reg;
    logic [5:0]         lvl_reg;
    logic signed [63:0] lp_reg;
    logic               started_reg;
    logic               out_valid_reg;
    logic [2:0]         out_status_reg;
    logic [6:0]         out_count_reg;
    logic signed [63:0] out_price_reg;
    logic [53:0]        out_volume_reg;
    logic [6:0]         out_quotes_reg;

    logic [CW-1:0]      fill;
    logic [EW-1:0]      rdata;
    logic [CW-1:0]      raddr_c;
    logic               we;
    logic [EW-1:0]      wdata;
    logic [62:0]        e_key;
    logic signed [63:0] e_price;
    logic [47:0]        e_vol;
    logic [1:0]         inst_mod;
    logic [SW-1:0]      sd_in;
    logic               new_run;
    logic               q_found;

    assign fill = fill_reg[sd_reg];
    assign {e_key, e_price, e_vol} = rdata;

    // instrument index wraps at INSTRUMENTS; the modulo is folded per code
    always_comb begin
        case (s_instrument)
            2'd0:    inst_mod = 2'(0 % INSTRUMENTS);
            2'd1:    inst_mod = 2'(1 % INSTRUMENTS);
            2'd2:    inst_mod = 2'(2 % INSTRUMENTS);
            default: inst_mod = 2'(3 % INSTRUMENTS);
        endcase
        sd_in = SW'({inst_mod, s_side});
    end

    always_comb begin
        raddr_c = ptr_reg;
        if (rm_ph_reg) begin
            raddr_c = ptr_reg + CW'(1);
        end else if (ins_ph_reg) begin
            raddr_c = ptr_reg - CW'(1);
        end
    end

    always_comb begin
        we    = cmd.sh_wr || cmd.is_wr;
        wdata = rdata;
        if (cmd.is_wr && ptr_reg == pos_reg) begin
            wdata = {qkey_reg, price_reg, vol_reg};
        end
    end

    sqb_ram #(.WIDTH(EW), .DEPTH(1 << MA)) u_mem (
        .aclk  (aclk),
        .we    (we),
        .waddr ({sd_reg, ptr_reg[AW-1:0]}),
        .wdata (wdata),
        .raddr ({sd_reg, raddr_c[AW-1:0]}),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg    <= s_op;
            sd_reg    <= sd_in;
            bid_reg   <= s_side;
            qkey_reg  <= s_quote_key;
            rkey_reg  <= s_ref_key;
            price_reg <= s_price;
            vol_reg   <= s_volume;
            want_reg  <= s_level_index;
        end
    end

    // scan pointer
    always_ff @(posedge aclk) begin
        if (cmd.rm_init || cmd.q_init || cmd.ins_init) begin
            ptr_reg    <= '0;
            rm_ph_reg  <= 1'b0;
            ins_ph_reg <= 1'b0;
        end else if (cmd.rm_hit) begin
            rm_ph_reg <= 1'b1;
        end else if (cmd.ins_hit) begin
            pos_reg    <= ptr_reg;
            ptr_reg    <= fill;
            ins_ph_reg <= 1'b1;
        end else if (cmd.step || cmd.sh_wr) begin
            ptr_reg <= ptr_reg + CW'(1);
        end else if (cmd.is_wr) begin
            ptr_reg <= ptr_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            status_reg <= sqb_pkg::ST_OK;
        end else if (cmd.set_st) begin
            status_reg <= cmd.st;
        end
    end

    assign new_run = started_reg && e_price != lp_reg;
    assign q_found = started_reg && lvl_reg == want_reg;

    // level accumulation over contiguous equal-price runs
    always_ff @(posedge aclk) begin
        if (cmd.q_init) begin
            sum_reg     <= '0;
            cnt_reg     <= '0;
            lvl_reg     <= '0;
            started_reg <= 1'b0;
        end else if (cmd.q_acc) begin
            if (new_run) begin
                sum_reg <= 54'(e_vol);
                cnt_reg <= CW'(1);
                lvl_reg <= lvl_reg + 6'd1;
            end else begin
                sum_reg <= sum_reg + 54'(e_vol);
                cnt_reg <= cnt_reg + CW'(1);
            end
            lp_reg      <= e_price;
            started_reg <= 1'b1;
        end
    end

    always_comb begin
        st           = '0;
        st.op        = op_reg;
        st.fill_zero = fill == '0;
        st.full      = fill >= CW'(DEPTH);
        st.rkey_zero = rkey_reg == '0;
        st.key_match = e_key == rkey_reg;
        st.out_busy  = out_valid_reg && !m_ready;
        st.is_end    = ptr_reg == pos_reg;
        st.ptr_end   = ptr_reg >= fill;
        st.ptr_last  = (ptr_reg + CW'(1)) >= fill;
        if (bid_reg) begin
            st.here = (e_price != price_reg) ? (price_reg > e_price) : (vol_reg >= e_vol);
        end else begin
            st.here = (e_price != price_reg) ? (e_price > price_reg) : (vol_reg >= e_vol);
        end
        st.q_done = new_run && lvl_reg == want_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SIDES; i = i + 1) begin
                fill_reg[i] <= '0;
            end
        end else if (cmd.fill_dec) begin
            fill_reg[sd_reg] <= fill - CW'(1);
        end else if (cmd.fill_inc) begin
            fill_reg[sd_reg] <= fill + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            out_count_reg  <= 7'(fill);
            out_price_reg  <= '0;
            out_volume_reg <= '0;
            out_quotes_reg <= '0;
            out_status_reg <= status_reg;
            if (op_reg == sqb_pkg::OP_QUERY) begin
                if (q_found) begin
                    out_status_reg <= sqb_pkg::ST_OK;
                    out_price_reg  <= lp_reg;
                    out_volume_reg <= sum_reg;
                    out_quotes_reg <= 7'(cnt_reg);
                end else begin
                    out_status_reg <= sqb_pkg::ST_NO_LEVEL;
                end
            end
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_status       = out_status_reg;
    assign m_side_count   = out_count_reg;
    assign m_level_price  = out_price_reg;
    assign m_level_volume = out_volume_reg;
    assign m_level_quotes = out_quotes_reg;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fill_inc |-> fill < CW'(DEPTH))
        else $error("insert into full side");
    a_dec_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fill_dec |-> fill != '0)
        else $error("remove from empty side");
    a_hold_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |-> !cmd.out_load)
        else $error("result overwritten");
endmodule

// File: sv/sorted_quote_book_top.sv
// Top level of the sorted quote book: controller plus datapath.
// Depends on sqb_pkg, sqb_ctrl, sqb_dp (and sqb_ram through sqb_dp).
// Each entry scanned or shifted is read, then compared or written; an update runs a
// removal, then an insertion.
// Throughput: one item at a time; next item accepted the cycle after the result is
// loaded, which waits while an earlier result is still held at the output.
// Reset: aresetn synchronous, clears fill counts and handshake state; memory is not cleared.
module sorted_quote_book_top #(
    parameter int DEPTH       = 64,
    parameter int INSTRUMENTS = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_op,
    input  logic [1:0]         s_instrument,
    input  logic               s_side,
    input  logic [62:0]        s_quote_key,
    input  logic [62:0]        s_ref_key,
    input  logic signed [63:0] s_price,
    input  logic [47:0]        s_volume,
    input  logic [5:0]         s_level_index,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_status,
    output logic [6:0]         m_side_count,
    output logic signed [63:0] m_level_price,
    output logic [53:0]        m_level_volume,
    output logic [6:0]         m_level_quotes
);
    sqb_pkg::cmd_t  cmd;
    sqb_pkg::stat_t st;

    sqb_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .st(st), .cmd(cmd)
    );

    sqb_dp #(.DEPTH(DEPTH), .INSTRUMENTS(INSTRUMENTS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .st(st),
        .s_op(s_op), .s_instrument(s_instrument), .s_side(s_side),
        .s_quote_key(s_quote_key), .s_ref_key(s_ref_key), .s_price(s_price),
        .s_volume(s_volume), .s_level_index(s_level_index),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_side_count(m_side_count), .m_level_price(m_level_price),
        .m_level_volume(m_level_volume), .m_level_quotes(m_level_quotes)
    );
endmodule

// File: sim/sorted_quote_book_checker.sv
// Checker for the sorted quote book: watches both channels, keeps a shadow book,
// predicts each result and compares it field by field. Depends on sqb_pkg.
`timescale 1ns / 100ps
module sorted_quote_book_checker #(
    parameter int DEPTH       = 64,
    parameter int INSTRUMENTS = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [1:0]         s_op,
    input  logic [1:0]         s_instrument,
    input  logic               s_side,
    input  logic [62:0]        s_quote_key,
    input  logic [62:0]        s_ref_key,
    input  logic signed [63:0] s_price,
    input  logic [47:0]        s_volume,
    input  logic [5:0]         s_level_index,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [2:0]         m_status,
    input  logic [6:0]         m_side_count,
    input  logic signed [63:0] m_level_price,
    input  logic [53:0]        m_level_volume,
    input  logic [6:0]         m_level_quotes,
    output int                 fail_count,
    output int                 pending_count
);

    typedef struct packed {
        logic [2:0]         status;
        logic [6:0]         side_count;
        logic signed [63:0] level_price;
        logic [53:0]        level_volume;
        logic [6:0]         level_quotes;
    } book_result_t;

    localparam int SIDES = INSTRUMENTS * 2;

    logic [62:0]        shadow_key [SIDES][DEPTH];
    logic signed [63:0] shadow_price [SIDES][DEPTH];
    logic [47:0]        shadow_vol [SIDES][DEPTH];
    int                 shadow_fill [SIDES];
    book_result_t       expected_q[$];
    int                 fails = 0;

    assign fail_count = fails;
    assign pending_count = expected_q.size();

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: mismatch on %s: got %0h expected %0h", $time, what, got, want);
        fails++;
    endtask

    function automatic book_result_t apply_book_op(
        input logic [1:0] op, input logic [1:0] inst, input logic bid,
        input logic [62:0] qkey, input logic [62:0] rkey,
        input logic signed [63:0] price, input logic [47:0] vol, input logic [5:0] want);
        book_result_t r;
        int s, n, pos, lvl, i;
        bit found, here, hit;
        logic signed [63:0] p;
        logic [53:0] sum;
        r = '0;
        s = (int'(inst) % INSTRUMENTS) * 2 + int'(bid);
        if (op == sqb_pkg::OP_UPDATE || op == sqb_pkg::OP_DELETE) begin
            if (rkey == 0 || shadow_fill[s] == 0) begin
                r.status = sqb_pkg::ST_MISSING;
            end else begin
                found = 0;
                for (i = 0; i < shadow_fill[s]; i++) begin
                    if (shadow_key[s][i] == rkey) begin
                        for (int j = i; j + 1 < shadow_fill[s]; j++) begin
                            shadow_key[s][j] = shadow_key[s][j+1];
                            shadow_price[s][j] = shadow_price[s][j+1];
                            shadow_vol[s][j] = shadow_vol[s][j+1];
                        end
                        shadow_fill[s]--;
                        found = 1;
                        break;
                    end
                end
                if (!found) r.status = sqb_pkg::ST_NOT_FOUND;
            end
        end
        if (op == sqb_pkg::OP_NEW || op == sqb_pkg::OP_UPDATE) begin
            n = shadow_fill[s];
            if (n >= DEPTH) begin
                r.status = sqb_pkg::ST_FULL;
            end else begin
                pos = n;
                for (i = 0; i < n; i++) begin
                    if (shadow_price[s][i] != price)
                        here = bid ? (price > shadow_price[s][i]) : (shadow_price[s][i] > price);
                    else
                        here = vol >= shadow_vol[s][i];
                    if (here) begin
                        pos = i;
                        break;
                    end
                end
                for (i = n; i > pos; i--) begin
                    shadow_key[s][i] = shadow_key[s][i-1];
                    shadow_price[s][i] = shadow_price[s][i-1];
                    shadow_vol[s][i] = shadow_vol[s][i-1];
                end
                shadow_key[s][pos] = qkey;
                shadow_price[s][pos] = price;
                shadow_vol[s][pos] = vol;
                shadow_fill[s] = n + 1;
            end
        end
        if (op == sqb_pkg::OP_QUERY) begin
            n = shadow_fill[s];
            i = 0;
            lvl = 0;
            hit = 0;
            while (i < n && !hit) begin
                p = shadow_price[s][i];
                sum = 0;
                pos = 0;
                while (i < n && shadow_price[s][i] == p) begin
                    sum += shadow_vol[s][i];
                    pos++;
                    i++;
                end
                if (lvl == int'(want)) begin
                    r.level_price = p;
                    r.level_volume = sum;
                    r.level_quotes = pos[6:0];
                    hit = 1;
                end
                lvl++;
            end
            if (!hit) r.status = sqb_pkg::ST_NO_LEVEL;
        end
        r.side_count = shadow_fill[s][6:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        book_result_t want;
        book_result_t pred;
        if (!aresetn) begin
            for (int k = 0; k < SIDES; k++) shadow_fill[k] = 0;
            expected_q.delete();
        end else begin
            if (s_valid && s_ready) begin
                pred = apply_book_op(s_op, s_instrument, s_side, s_quote_key,
                    s_ref_key, s_price, s_volume, s_level_index);
                expected_q.insert(expected_q.size(), pred);
            end
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected result", 64'(1), 64'(0));
                end else begin
                    want = expected_q.pop_front();
                    if (m_status !== want.status)
                        report_mismatch("status", 64'(m_status), 64'(want.status));
                    if (m_side_count !== want.side_count)
                        report_mismatch("side_count", 64'(m_side_count), 64'(want.side_count));
                    if (m_level_price !== want.level_price)
                        report_mismatch("level_price", m_level_price, want.level_price);
                    if (m_level_volume !== want.level_volume)
                        report_mismatch("level_volume", 64'(m_level_volume),
                                        64'(want.level_volume));
                    if (m_level_quotes !== want.level_quotes)
                        report_mismatch("level_quotes", 64'(m_level_quotes),
                                        64'(want.level_quotes));
                end
            end
        end
    end

endmodule

// File: sim/sorted_quote_book_top_test.sv
// Testbench top for the sorted quote book: clock, reset, stimulus and verdict.
// Depends on sqb_pkg, sorted_quote_book_top and sorted_quote_book_checker.
`timescale 1ns / 100ps
module sorted_quote_book_top_test;

    logic               aclk = 0;
    logic               aresetn = 0;
    logic               s_valid = 0;
    logic               s_ready;
    logic [1:0]         s_op = '0;
    logic [1:0]         s_instrument = '0;
    logic               s_side = 0;
    logic [62:0]        s_quote_key = '0;
    logic [62:0]        s_ref_key = '0;
    logic signed [63:0] s_price = '0;
    logic [47:0]        s_volume = '0;
    logic [5:0]         s_level_index = '0;
    logic               m_valid;
    logic               m_ready = 0;
    logic [2:0]         m_status;
    logic [6:0]         m_side_count;
    logic signed [63:0] m_level_price;
    logic [53:0]        m_level_volume;
    logic [6:0]         m_level_quotes;
    int                 fail_count, pending_count;
    int                 send_idle_pct = 0, recv_stall_pct = 0;
    logic [62:0]        next_key = 1;
    logic [62:0]        live_keys[$];

    always #6 aclk = ~aclk;

    sorted_quote_book_top dut (.*);
    sorted_quote_book_checker checker_i (.*);

    always @(posedge aclk)
        m_ready <= ($urandom_range(99) >= recv_stall_pct);

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // valid stays high from one item to the next unless the sender idles
    task automatic send_quote(input logic [1:0] op, input logic [1:0] inst, input logic bid,
                              input logic [62:0] qkey, input logic [62:0] rkey,
                              input logic signed [63:0] price, input logic [47:0] vol,
                              input logic [5:0] lvl);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1;
        s_op <= op;
        s_instrument <= inst;
        s_side <= bid;
        s_quote_key <= qkey;
        s_ref_key <= rkey;
        s_price <= price;
        s_volume <= vol;
        s_level_index <= lvl;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Mostly well-formed traffic: fresh keys, references to live quotes, a narrow
    // price band so levels collect several quotes; some wide values and stale refs.
    task automatic random_quote();
        logic [1:0] op;
        logic [62:0] rkey, qkey;
        logic signed [63:0] price;
        logic [47:0] vol;
        int idx;
        op = 2'($urandom_range(3));
        qkey = ($urandom_range(9) == 0) ? 63'(rand64()) : next_key;
        next_key++;
        if (live_keys.size() > 0 && $urandom_range(9) < 8) begin
            idx = $urandom_range(live_keys.size() - 1);
            rkey = live_keys[idx];
            if (op == sqb_pkg::OP_UPDATE || op == sqb_pkg::OP_DELETE) live_keys.delete(idx);
        end else begin
            rkey = ($urandom_range(3) == 0) ? '0 : 63'(rand64());
        end
        if (op == sqb_pkg::OP_NEW || op == sqb_pkg::OP_UPDATE)
            live_keys.insert(live_keys.size(), qkey);
        price = ($urandom_range(7) == 0) ? rand64() : 64'($signed($urandom_range(20)) - 10);
        vol = ($urandom_range(7) == 0) ? 48'(rand64()) : 48'($urandom_range(5));
        send_quote(op, 2'($urandom_range(3)), 1'($urandom_range(1)), qkey, rkey, price, vol,
                   ($urandom_range(3) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(4)));
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // directed: empty side, missing references, extremes, level queries
        send_quote(sqb_pkg::OP_DELETE, 0, 0, 5, 5, 0, 0, 0);
        send_quote(sqb_pkg::OP_QUERY, 0, 1, 0, 0, 0, 0, 0);
        send_quote(sqb_pkg::OP_NEW, 0, 1, '1, 0, 64'sh7FFFFFFFFFFFFFFF, '1, 0);
        send_quote(sqb_pkg::OP_NEW, 0, 1, 1, 0, 64'sh8000000000000000, 0, 0);
        send_quote(sqb_pkg::OP_NEW, 0, 1, 2, 0, 64'sh7FFFFFFFFFFFFFFF, '1, 0);
        send_quote(sqb_pkg::OP_NEW, 0, 1, 3, 0, 64'sh7FFFFFFFFFFFFFFF, 1, 0);
        send_quote(sqb_pkg::OP_QUERY, 0, 1, 0, 0, 0, 0, 0);
        send_quote(sqb_pkg::OP_QUERY, 0, 1, 0, 0, 0, 0, 1);
        send_quote(sqb_pkg::OP_QUERY, 0, 1, 0, 0, 0, 0, 63);
        send_quote(sqb_pkg::OP_UPDATE, 0, 1, 4, 0, -5, 7, 0);
        send_quote(sqb_pkg::OP_DELETE, 0, 1, 0, 999, 0, 0, 0);
        send_quote(sqb_pkg::OP_UPDATE, 0, 1, 6, 999, 3, 3, 0);
        send_quote(sqb_pkg::OP_UPDATE, 0, 1, 7, 2, 3, 3, 0);
        send_quote(sqb_pkg::OP_DELETE, 0, 1, 0, '1, 0, 0, 0);
        send_quote(sqb_pkg::OP_NEW, 3, 0, 8, 0, -1, 1, 0);
        send_quote(sqb_pkg::OP_NEW, 3, 0, 9, 0, 64'sh8000000000000000, 2, 0);
        send_quote(sqb_pkg::OP_QUERY, 3, 0, 0, 0, 0, 0, 0);
        // fill one ask side past capacity
        for (int i = 0; i < 66; i++)
            send_quote(sqb_pkg::OP_NEW, 2, 0, 63'(100 + i), 0, 64'($urandom_range(3)),
                       48'(i), 0);
        send_quote(sqb_pkg::OP_UPDATE, 2, 0, 500, 100, 1, 1, 0);
        send_quote(sqb_pkg::OP_UPDATE, 2, 0, 501, 77777, 1, 1, 0);
        send_quote(sqb_pkg::OP_QUERY, 2, 0, 0, 0, 0, 0, 2);
        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct = (phase == 1 || phase == 3) ? (phase == 1 ? 67 : 24) : 0;
            recv_stall_pct = (phase == 2 || phase == 3) ? (phase == 2 ? 67 : 24) : 0;
            for (int i = 0; i < 330; i++) random_quote();
        end
        s_valid <= 0;
        recv_stall_pct = 0;
        while (pending_count != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #200ms;
        $display("Some tests failed");
        $finish;
    end

endmodule
